// ===== rtl/sorted_key_node_table_macros.svh =====
// Assertion macros for the sorted key node table.
// Used by the top level only; no other dependencies.
`ifndef SORTED_KEY_NODE_TABLE_MACROS_SVH
`define SORTED_KEY_NODE_TABLE_MACROS_SVH

// same-cycle implication
`define SKNT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SKNT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sknt_pkg.sv =====
// Shared types and codes for the sorted key node table.
// No dependencies.
package sknt_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_BITS_DEF = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_ROUTE  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_DUP  = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic eq;
      logic gt;
      logic ge;
   } cmp_flags_type;

endpackage

// ===== rtl/sknt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sknt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sknt_cmp.sv =====
// Shared key comparator used by every search probe and the match check.
// Depends on sknt_pkg.
module sknt_cmp import sknt_pkg::*; #(
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  logic [KEY_BITS-1:0] stored_key,
   input  logic [KEY_BITS-1:0] probe_key,
   output cmp_flags_type       flags
);

   always_comb begin
      flags.eq = (stored_key == probe_key);
      flags.gt = (stored_key > probe_key);
      flags.ge = (stored_key >= probe_key);
   end

endmodule

// ===== rtl/sorted_key_node_table.sv =====
// Top level of the sorted key node table: sequencer, table RAM and comparator.
// Depends on sknt_pkg, sknt_ram, sknt_cmp and sorted_key_node_table_macros.svh.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low; req_op,
//   req_search_key, req_new_page and req_new_slot are sampled there. busy stays
//   high until the result is out. Each transaction gives one result, shown for
//   one cycle with rsp_valid high; the receiver cannot stall it.
//   Sequence, with n entries in the table and p the key's position:
//     binary search: each probe is a RAM read (S_SEARCH) and a compare (S_CMP),
//       then the entry at the final position is fetched and checked (S_FETCH);
//     insert: entries p..n-1 move up, one entry moved per cycle (S_SHIFT),
//       then the new entry is written at p (S_FINAL);
//     remove: entries p+1..n-1 move down, same shift path;
//     route lookup on an empty table: result the cycle after start.
//   The pace is set by the single RAM read port with registered data.
//   Reset empties the table at once; the RAM is not cleared.
`include "sorted_key_node_table_macros.svh"
module sorted_key_node_table import sknt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [31:0]        req_search_key,
   input  logic [31:0]        req_new_page,
   input  logic signed [31:0] req_new_slot,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_position,
   output logic [31:0]        rsp_found_page,
   output logic signed [31:0] rsp_found_slot,
   output logic [6:0]         rsp_entries_now
);

   localparam int AW      = $clog2(CAPACITY);
   localparam int CW      = $clog2(CAPACITY + 1);
   localparam int EW      = KEY_BITS + 64;
   localparam int SrcBits = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);
   localparam logic [CW-1:0] One    = CW'(1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_CMP    = 3'd2;
   localparam logic [2:0] S_FETCH  = 3'd3;
   localparam logic [2:0] S_SHIFT  = 3'd4;
   localparam logic [2:0] S_FINAL  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [31:0]         page_ff, page_in;
   logic [31:0]         slot_ff, slot_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       mid_ff, mid_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       cur_ff, cur_in;
   logic                wpend_ff, wpend_in;
   logic [AW-1:0]       waddr_ff, waddr_in;
   logic                valid_ff, valid_in;
   logic [1:0]          status_ff, status_in;
   logic [6:0]          pos_ff, pos_in;
   logic [31:0]         fpage_ff, fpage_in;
   logic [31:0]         fslot_ff, fslot_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [EW-1:0]       ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [EW-1:0]       ram_rdata;
   logic [KEY_BITS-1:0] rd_key;
   logic [31:0]         rd_page;
   logic [31:0]         rd_slot;
   cmp_flags_type       flags;
   logic [CW:0]         lo_hi_sum;
   logic [CW-1:0]       mid;
   logic [CW-1:0]       lo_dec;
   logic [CW-1:0]       cur_inc;
   logic [CW-1:0]       cur_dec;
   logic                hit;

   sknt_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_key  = ram_rdata[EW-1:64];
   assign rd_page = ram_rdata[63:32];
   assign rd_slot = ram_rdata[31:0];

   sknt_cmp #(
      .KEY_BITS (KEY_BITS)
   ) u_cmp (
      .stored_key (rd_key),
      .probe_key  (key_ff),
      .flags      (flags)
   );

   assign lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = lo_hi_sum[CW:1];
   assign lo_dec    = lo_ff - One;
   assign cur_inc   = cur_ff + One;
   assign cur_dec   = cur_ff - One;
   assign hit       = (lo_ff < count_ff) && flags.eq;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      page_in   = page_ff;
      slot_in   = slot_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      wpend_in  = wpend_ff;
      waddr_in  = waddr_ff;
      valid_in  = 1'b0;
      status_in = status_ff;
      pos_in    = pos_ff;
      fpage_in  = fpage_ff;
      fslot_in  = fslot_ff;
      ram_we    = 1'b0;
      ram_waddr = waddr_ff;
      ram_wdata = ram_rdata;
      ram_raddr = lo_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = req_op;
               key_in  = KEY_BITS'(req_search_key[SrcBits-1:0]);
               page_in = req_new_page;
               slot_in = $unsigned(req_new_slot);
               lo_in   = (req_op == OP_ROUTE) ? One : '0;
               hi_in   = count_ff;
               if (req_op == OP_ROUTE && count_ff == '0) begin
                  valid_in  = 1'b1;
                  status_in = ST_MISS;
                  pos_in    = '0;
                  fpage_in  = '0;
                  fslot_in  = '0;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               ram_raddr = mid[AW-1:0];
               mid_in    = mid;
               state_in  = S_CMP;
            end else begin
               ram_raddr = (op_ff == OP_ROUTE) ? lo_dec[AW-1:0] : lo_ff[AW-1:0];
               state_in  = S_FETCH;
            end
         end
         S_CMP: begin
            if ((op_ff == OP_ROUTE) ? flags.gt : flags.ge) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + One;
            end
            state_in = S_SEARCH;
         end
         S_FETCH: begin
            pos_in   = 7'(lo_ff);
            fpage_in = '0;
            fslot_in = '0;
            wpend_in = 1'b0;
            case (op_ff)
               OP_ROUTE: begin
                  pos_in    = 7'(lo_dec);
                  status_in = ST_OK;
                  fpage_in  = rd_page;
                  fslot_in  = rd_slot;
                  valid_in  = 1'b1;
                  state_in  = S_IDLE;
               end
               OP_INSERT: begin
                  if (hit) begin
                     status_in = ST_DUP;
                     valid_in  = 1'b1;
                     state_in  = S_IDLE;
                  end else if (count_ff >= CapCnt) begin
                     status_in = ST_FULL;
                     valid_in  = 1'b1;
                     state_in  = S_IDLE;
                  end else begin
                     cur_in   = count_ff;
                     state_in = S_SHIFT;
                  end
               end
               default: begin
                  if (!hit) begin
                     status_in = ST_MISS;
                     valid_in  = 1'b1;
                     state_in  = S_IDLE;
                  end else begin
                     fpage_in = rd_page;
                     fslot_in = rd_slot;
                     if (op_ff == OP_REMOVE) begin
                        cur_in   = lo_ff;
                        state_in = S_SHIFT;
                     end else begin
                        status_in = ST_OK;
                        valid_in  = 1'b1;
                        state_in  = S_IDLE;
                     end
                  end
               end
            endcase
         end
         S_SHIFT: begin
            ram_we = wpend_ff;
            if (op_ff == OP_INSERT && cur_ff > lo_ff) begin
               ram_raddr = cur_dec[AW-1:0];
               waddr_in  = cur_ff[AW-1:0];
               wpend_in  = 1'b1;
               cur_in    = cur_dec;
            end else if (op_ff == OP_REMOVE && cur_inc < count_ff) begin
               ram_raddr = cur_inc[AW-1:0];
               waddr_in  = cur_ff[AW-1:0];
               wpend_in  = 1'b1;
               cur_in    = cur_inc;
            end else begin
               wpend_in = 1'b0;
               if (!wpend_ff) begin
                  state_in = S_FINAL;
               end
            end
         end
         S_FINAL: begin
            status_in = ST_OK;
            valid_in  = 1'b1;
            state_in  = S_IDLE;
            if (op_ff == OP_INSERT) begin
               ram_we    = 1'b1;
               ram_waddr = lo_ff[AW-1:0];
               ram_wdata = {key_ff, page_ff, slot_ff};
               count_in  = count_ff + One;
            end else begin
               count_in  = count_ff - One;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         wpend_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         wpend_ff <= wpend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      page_ff   <= page_in;
      slot_ff   <= slot_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      cur_ff    <= cur_in;
      waddr_ff  <= waddr_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      fpage_ff  <= fpage_in;
      fslot_ff  <= fslot_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = pos_ff;
   assign rsp_found_page  = fpage_ff;
   assign rsp_found_slot  = $signed(fslot_ff);
   assign rsp_entries_now = 7'(count_ff);

   `SKNT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CapCnt,
      "count above capacity")
   `SKNT_ASSERT_NXT(a_accept_busy, clock, reset,
      start && !busy && (count_ff != '0 || req_op != OP_ROUTE), busy,
      "accepted transaction did not raise busy")
   `SKNT_ASSERT_IMP(a_full_status, clock, reset, rsp_valid && rsp_status == ST_FULL,
      count_ff == CapCnt, "full status with room left")
   `SKNT_ASSERT_IMP(a_shift_write, clock, reset, state_ff == S_SHIFT && ram_we,
      {1'b0, waddr_ff} <= {1'b0, count_ff}, "shift write beyond table end")

endmodule
